// ===== rtl/tef_pkg.sv =====
`default_nettype none

package tef_pkg;

    // Field widths of the word formats
    localparam int DataW    = 24;
    localparam int DeltaW   = 16;
    localparam int TimeW    = 32;
    localparam int StatusW  = 2;

    // Input kind, carried on s_tuser
    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_GET = 1'b1;

    // Result status, carried on m_tuser
    localparam logic [StatusW-1:0] STAT_OK    = 2'd0;
    localparam logic [StatusW-1:0] STAT_EMPTY = 2'd1;
    localparam logic [StatusW-1:0] STAT_ERROR = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the incoming word
        logic commit;    // update the queue and load the result register
    } tef_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;  // result register empty or being emptied this cycle
    } tef_sts_t;

endpackage

`default_nettype wire

// ===== rtl/timestamped_event_fifo.sv =====
`default_nettype none

// Timestamped event queue. Each input word either puts a message (s_tuser
// low) or gets the oldest one (s_tuser high). A put adds its delta, which
// must be non-negative, to a running put clock and stores the message with
// that absolute time in a ring of DEPTH entries; a negative delta or a full
// ring gives an error word and leaves everything unchanged. A get returns
// the oldest message, its time, and the pulses elapsed since the time of
// the previous successful get; a get on an empty ring returns the empty
// status with an all-ones time. Every input word yields exactly one result
// word, in order. All times and differences wrap modulo 2^32. An operation
// first captures the word while the ring memory presents the head entry
// through its registered read port, then updates the pointers and loads
// the result register once that register can take the outcome. A new word
// is taken only after the previous operation has completed. The result
// register is separate, so a new word is accepted while a result waits on
// m_tready; only the completion of that next word waits for it to drain.
// Ring contents are not cleared at reset and need no clearing pass.
module timestamped_event_fifo
    import tef_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int MSG_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // msg_data[23:0], delta_pulses[39:24]
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // out_data[23:0], out_time[55:24],
                                        // elapsed_pulses[87:56]
    output logic [1:0]       m_tuser    // status
);

    tef_cmd_t           cmd;
    tef_sts_t           sts;
    logic [StatusW-1:0] res_status;
    logic [DataW-1:0]   res_data;
    logic [TimeW-1:0]   res_time;
    logic [TimeW-1:0]   res_elapsed;

    // Sequencing of each word: capture, then commit once the result
    // register can take the outcome.
    tef_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Ring memory, pointers, both clocks and the result register.
    tef_datapath #(
        .DEPTH    (DEPTH),
        .MSG_BITS (MSG_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_mode         (s_tuser),
        .in_msg_data     (s_tdata[23:0]),
        .in_delta_pulses (signed'(s_tdata[39:24])),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (res_status),
        .out_data        (res_data),
        .out_time        (res_time),
        .out_elapsed     (res_elapsed)
    );

    assign m_tuser = res_status;
    assign m_tdata = {res_elapsed, res_time, res_data};

    // After a word is accepted the input side is closed in the next cycle
    // while the operation completes.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation was in progress");

    // A commit never happens while the input side is open.
    a_commit_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !s_tready)
        else $error("commit while idle");

    // An empty result carries no message, an all-ones time and no elapsed time.
    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_EMPTY) |->
            (m_tdata[23:0] == '0) && (m_tdata[55:24] == '1) && (m_tdata[87:56] == '0))
        else $error("malformed empty result");

    // An error result carries all-zero payload.
    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_ERROR) |-> (m_tdata == '0))
        else $error("malformed error result");

endmodule

`default_nettype wire

// ===== rtl/tef_ctrl.sv =====
`default_nettype none

module tef_ctrl
    import tef_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  tef_sts_t      sts,
    output tef_cmd_t      cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Words are taken only between operations; the result register is
    // decoupled, so a waiting result does not hold off the input side.
    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.load_in = s_tvalid && s_tready;
    assign cmd.commit  = (state_reg == ST_EXEC) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load_in) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tef_datapath.sv =====
`default_nettype none

module tef_datapath
    import tef_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int MSG_BITS = 24
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  tef_cmd_t                       cmd,
    output tef_sts_t                       sts,
    input  wire logic                      in_mode,
    input  wire logic [DataW-1:0]          in_msg_data,
    input  wire logic signed [DeltaW-1:0]  in_delta_pulses,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [StatusW-1:0]             out_status,
    output logic [DataW-1:0]               out_data,
    output logic [TimeW-1:0]               out_time,
    output logic [TimeW-1:0]               out_elapsed
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int MsgWide = (MSG_BITS > DataW) ? MSG_BITS : DataW;

    // Entry storage
    logic [MSG_BITS-1:0] msg_mem  [DEPTH];
    logic [TimeW-1:0]    time_mem [DEPTH];
    logic [MSG_BITS-1:0] rd_msg_reg;
    logic [TimeW-1:0]    rd_time_reg;

    // Captured input word
    logic                      mode_reg;
    logic [DataW-1:0]          msg_reg;
    logic signed [DeltaW-1:0]  delta_reg;

    // Queue state
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [TimeW-1:0] put_clk_reg, put_clk_next;
    logic [TimeW-1:0] get_clk_reg, get_clk_next;

    // Result register
    logic               valid_reg;
    logic [StatusW-1:0] status_reg, status_next;
    logic [DataW-1:0]   data_reg, data_next;
    logic [TimeW-1:0]   time_reg, time_next;
    logic [TimeW-1:0]   elapsed_reg, elapsed_next;

    logic               full;
    logic               empty;
    logic               put_ok;
    logic               get_ok;
    logic [TimeW-1:0]   delta_ext;
    logic [TimeW-1:0]   put_time;
    logic [MsgWide-1:0] wr_wide;
    logic [MsgWide-1:0] rd_wide;
    logic [MSG_BITS-1:0] wr_msg;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign put_ok    = (mode_reg == MODE_PUT) && !delta_reg[DeltaW-1] && !full;
    assign get_ok    = (mode_reg == MODE_GET) && !empty;
    assign delta_ext = TimeW'(unsigned'(delta_reg));
    assign put_time  = put_clk_reg + delta_ext;
    assign wr_wide   = MsgWide'(msg_reg);
    assign wr_msg    = wr_wide[MSG_BITS-1:0];
    assign rd_wide   = MsgWide'(rd_msg_reg);

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        put_clk_next = put_clk_reg;
        get_clk_next = get_clk_reg;
        status_next  = STAT_OK;
        data_next    = '0;
        time_next    = '0;
        elapsed_next = '0;
        if (mode_reg == MODE_PUT) begin
            if (put_ok) begin
                put_clk_next = put_time;
                tail_next    = wrap_inc(tail_reg);
                count_next   = count_reg + 1'b1;
                time_next    = put_time;
                elapsed_next = delta_ext;
            end else begin
                status_next = STAT_ERROR;
            end
        end else begin
            if (get_ok) begin
                get_clk_next = rd_time_reg;
                head_next    = wrap_inc(head_reg);
                count_next   = count_reg - 1'b1;
                data_next    = rd_wide[DataW-1:0];
                time_next    = rd_time_reg;
                elapsed_next = rd_time_reg - get_clk_reg;
            end else begin
                status_next = STAT_EMPTY;
                time_next   = '1;
            end
        end
    end

    // The head entry is read every cycle; the head only moves on a commit,
    // which is always followed by the idle state before the next operation.
    always_ff @(posedge aclk) begin
        if (cmd.commit && put_ok) begin
            msg_mem[tail_reg]  <= wr_msg;
            time_mem[tail_reg] <= put_time;
        end
        rd_msg_reg  <= msg_mem[head_reg];
        rd_time_reg <= time_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg  <= in_mode;
            msg_reg   <= in_msg_data;
            delta_reg <= in_delta_pulses;
        end
        if (cmd.commit) begin
            status_reg  <= status_next;
            data_reg    <= data_next;
            time_reg    <= time_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            put_clk_reg <= '0;
            get_clk_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (cmd.commit) begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                put_clk_reg <= put_clk_next;
                get_clk_reg <= get_clk_next;
                valid_reg   <= 1'b1;
            end else if (valid_reg && out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_status   = status_reg;
    assign out_data     = data_reg;
    assign out_time     = time_reg;
    assign out_elapsed  = elapsed_reg;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb;
    import tef_pkg::*;

    // The ring depth matches the instance below; the message width is the full field.
    localparam int RING_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 200_000;

    // One input word as the testbench sees it.
    typedef struct {
        logic                     mode;
        logic [DataW-1:0]         msg;
        logic signed [DeltaW-1:0] delta;
        bit                       rush;   // sent back to back, receiver always ready
    } event_word_t;

    // One result word, split into its fields.
    typedef struct {
        logic [StatusW-1:0] status;
        logic [DataW-1:0]   data;
        logic [TimeW-1:0]   stamp;
        logic [TimeW-1:0]   elapsed;
    } event_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;

    timestamped_event_fifo #(
        .DEPTH    (RING_DEPTH),
        .MSG_BITS (DataW)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // msg_data[23:0], delta_pulses[39:24]
        .s_tuser  (s_tuser),    // mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_data[23:0], out_time[55:24], elapsed_pulses[87:56]
        .m_tuser  (m_tuser)     // status
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predicted queue: a ring with its own put and get clocks.
    // ------------------------------------------------------------------
    logic [DataW-1:0] ring_msg   [RING_DEPTH];
    logic [TimeW-1:0] ring_stamp [RING_DEPTH];
    int unsigned      ring_head  = 0;
    int unsigned      ring_tail  = 0;
    int unsigned      ring_count = 0;
    logic [TimeW-1:0] put_clock  = '0;
    logic [TimeW-1:0] get_clock  = '0;

    // Tallies for the closing summary.
    int unsigned n_put_ok, n_put_negative, n_put_full, n_get_ok, n_get_empty;
    int unsigned n_backward_gets;
    bit          put_clock_wrapped = 1'b0;

    event_word_t   event_backlog[$];     // words still to be offered to the block
    event_result_t awaited_results[$];   // predicted results, oldest first

    int unsigned mismatches = 0;
    int unsigned cycles     = 0;

    // Works out the result of one accepted word and advances the predicted queue.
    function automatic event_result_t queue_response(event_word_t w);
        event_result_t    r;
        logic [TimeW-1:0] next_put;
        r.status  = STAT_OK;
        r.data    = '0;
        r.stamp   = '0;
        r.elapsed = '0;
        if (w.mode == MODE_PUT) begin
            if (w.delta[DeltaW-1]) begin
                // A negative delta is refused and the clock stays where it is.
                r.status = STAT_ERROR;
                n_put_negative++;
            end else if (ring_count == RING_DEPTH) begin
                r.status = STAT_ERROR;
                n_put_full++;
            end else begin
                next_put = put_clock + {16'b0, w.delta};
                if (next_put < put_clock) put_clock_wrapped = 1'b1;
                put_clock              = next_put;
                ring_msg[ring_tail]    = w.msg;
                ring_stamp[ring_tail]  = put_clock;
                ring_tail              = (ring_tail + 1) % RING_DEPTH;
                ring_count++;
                r.stamp   = put_clock;
                r.elapsed = {16'b0, w.delta};
                n_put_ok++;
            end
        end else if (ring_count == 0) begin
            r.status = STAT_EMPTY;
            r.stamp  = '1;
            n_get_empty++;
        end else begin
            r.data    = ring_msg[ring_head];
            r.stamp   = ring_stamp[ring_head];
            // The difference wraps; an entry time below the get clock is legal.
            r.elapsed = r.stamp - get_clock;
            if (r.stamp < get_clock) n_backward_gets++;
            get_clock = r.stamp;
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_count--;
            n_get_ok++;
        end
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [TimeW-1:0] want, logic [TimeW-1:0] seen);
        mismatches++;
        if (mismatches <= 10)
            $display("cycle %0d: %0s mismatch, expected %0h, got %0h", cycles, field, want, seen);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_event(logic mode, logic [DataW-1:0] msg,
                             logic signed [DeltaW-1:0] delta, bit rush);
        event_word_t w;
        w.mode  = mode;
        w.msg   = msg;
        w.delta = delta;
        w.rush  = rush;
        event_backlog.push_back(w);
    endtask

    // Random traffic in phases that lean towards puts, towards gets, or neither, so
    // that the ring is driven to full and back to empty many times over.
    task automatic add_random_events(int total);
        int                       put_pct;
        int                       phase_left;
        logic [DataW-1:0]         m;
        logic signed [DeltaW-1:0] d;
        put_pct    = 50;
        phase_left = 0;
        for (int i = 0; i < total; i++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       put_pct = 92;
                    1:       put_pct = 8;
                    default: put_pct = 55;
                endcase
                phase_left = $urandom_range(30, 110);
            end
            phase_left--;
            case ($urandom_range(0, 9))
                0:       m = '0;
                1:       m = '1;
                default: m = DataW'($urandom);
            endcase
            case ($urandom_range(0, 11))
                0:       d = '0;
                1:       d = 16'sh7fff;
                2:       d = {1'b1, 15'($urandom)};
                3, 4:    d = DeltaW'($urandom_range(0, 15));
                default: d = {1'b0, 15'($urandom)};
            endcase
            add_event(($urandom_range(0, 99) < put_pct) ? MODE_PUT : MODE_GET, m, d, 1'b0);
        end
    endtask

    initial begin
        // Directed opening: empty get, delta and message extremes, refused negative
        // deltas, alternating bit patterns, and draining back to empty.
        add_event(MODE_GET, 24'h000000, 16'sh0000, 1'b0);
        add_event(MODE_PUT, 24'h000000, 16'sh0000, 1'b0);
        add_event(MODE_PUT, 24'hffffff, 16'sh7fff, 1'b0);
        add_event(MODE_PUT, 24'h123456, -16'sd1, 1'b0);
        add_event(MODE_PUT, 24'hffffff, 16'sh8000, 1'b0);
        add_event(MODE_PUT, 24'haaaaaa, 16'sh0001, 1'b0);
        add_event(MODE_GET, 24'hffffff, 16'sh7fff, 1'b0);
        add_event(MODE_GET, 24'h000000, 16'sh8000, 1'b0);
        add_event(MODE_GET, 24'h000000, 16'sh0000, 1'b0);
        add_event(MODE_GET, 24'h000000, 16'sh0000, 1'b0);
        add_event(MODE_PUT, 24'h555555, 16'sh5555, 1'b0);
        add_event(MODE_PUT, 24'haaaaaa, 16'sh2aaa, 1'b0);
        add_event(MODE_PUT, 24'h0f0f0f, 16'sh0000, 1'b0);
        add_event(MODE_GET, 24'h000000, 16'sh0000, 1'b0);
        add_event(MODE_PUT, 24'hf0f0f0, -16'sd21846, 1'b0);
        add_event(MODE_GET, 24'h000000, 16'sh0000, 1'b0);
        add_event(MODE_GET, 24'h000000, 16'sh0000, 1'b0);
        add_event(MODE_GET, 24'h000000, 16'sh0000, 1'b0);
        add_event(MODE_PUT, 24'h800001, 16'sh4000, 1'b0);
        add_event(MODE_GET, 24'h000000, 16'sh0000, 1'b0);

        add_random_events(670);
        add_random_events(670);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to be taken, then for every result, then a short tail.
        while (event_backlog.size() != 0 || s_tvalid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        mismatches += awaited_results.size();

        $display("puts stored %0d, refused negative %0d, refused full %0d",
                 n_put_ok, n_put_negative, n_put_full);
        $display("gets returned %0d, empty %0d, behind the get clock %0d, put clock wrapped %0d",
                 n_get_ok, n_get_empty, n_backward_gets, put_clock_wrapped);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver and receiver, both moved on the falling edge.
    // ------------------------------------------------------------------
    bit          s_taken    = 1'b0;   // the word on s_tdata was taken at the last rising edge
    bit          rushing    = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned rx_style   = 0;
    int unsigned rx_left    = 0;

    always @(negedge aclk) begin : drive
        event_word_t w;
        logic        ready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            // A word stays on the bus until it has been taken.
            if (!s_tvalid || s_taken) begin
                if (gap_left > 0 || event_backlog.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    w = event_backlog.pop_front();
                    s_tdata  <= {w.delta, w.msg};
                    s_tuser  <= w.mode;
                    s_tvalid <= 1'b1;
                    rushing  = w.rush;
                    if (!w.rush) begin
                        if (burst_left <= 1) begin
                            // New burst; a quarter of bursts follow on with no gap.
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                        end else begin
                            burst_left--;
                        end
                    end
                end
            end

            // The receiver switches between always ready, random stalls and a regular
            // stall pattern, stalling while its countdown modulo 8 is below 3.
            if (rx_left == 0) begin
                rx_style = $urandom_range(0, 2);
                rx_left  = $urandom_range(16, 96);
            end else begin
                rx_left--;
            end
            case (rx_style)
                0:       ready = 1'b1;
                1:       ready = ($urandom_range(0, 9) < 6);
                default: ready = ((rx_left % 8) >= 3);
            endcase
            m_tready <= ready || rushing;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard on the rising edge. Results are checked before the
    // word accepted at the same edge is predicted, as that result is always older.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : score
        event_word_t   w;
        event_result_t want;
        event_result_t seen;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d words unsent and %0d results awaited",
                     cycles, event_backlog.size(), awaited_results.size());
            $display("DONE: errors detected");
            $finish;
        end else if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;

            if (m_tvalid && m_tready) begin
                seen.status  = m_tuser;
                seen.data    = m_tdata[23:0];
                seen.stamp   = m_tdata[55:24];
                seen.elapsed = m_tdata[87:56];
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cycle %0d: result word with none awaited, status %0h data %0h",
                                 cycles, seen.status, seen.data);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status)
                        note_mismatch("status", TimeW'(want.status), TimeW'(seen.status));
                    if (seen.data !== want.data)
                        note_mismatch("out_data", TimeW'(want.data), TimeW'(seen.data));
                    if (seen.stamp !== want.stamp)
                        note_mismatch("out_time", want.stamp, seen.stamp);
                    if (seen.elapsed !== want.elapsed)
                        note_mismatch("elapsed_pulses", want.elapsed, seen.elapsed);
                end
            end

            if (s_tvalid && s_tready) begin
                w.mode  = s_tuser;
                w.msg   = s_tdata[23:0];
                w.delta = s_tdata[39:24];
                w.rush  = 1'b0;
                awaited_results.push_back(queue_response(w));
            end
        end
    end

endmodule
